// ===== hdl/rsxbh_pkg.sv =====
// shared constants and helpers for the rolling shift-xor byte hash
`timescale 1ns / 1ps

package rsxbh_pkg;

  localparam int unsigned HASH_W  = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned SHAMT_W = 3;

  // hash value after reset and reset value of the seed register
  localparam logic [HASH_W-1:0] SEED_RESET = 32'hCA07_4011;

  // position runs 0 .. POS_MODULUS-1
  localparam int unsigned       POS_MODULUS = 24;
  localparam logic [POS_W-1:0]  POS_LAST    = POS_W'(POS_MODULUS - 1);

  // base of the second shift amount
  localparam logic [SHAMT_W-1:0] SHAMT_BASE = 3'd2;

  // hash state carried from word to word
  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [POS_W-1:0]  pos;
  } hash_state_t;

  // byte mod 6 built from its parity and its residue mod 3
  // (4 is 1 mod 3, so the 2-bit digits can simply be summed)
  function automatic logic [2:0] byte_mod6(input logic [BYTE_W-1:0] b);
    logic [3:0] dsum;
    logic [2:0] fold;
    logic [1:0] r3;
    dsum = {2'b00, b[1:0]} + {2'b00, b[3:2]} + {2'b00, b[5:4]} + {2'b00, b[7:6]};
    fold = {1'b0, dsum[1:0]} + {1'b0, dsum[3:2]};
    if (fold >= 3'd3) begin
      fold = fold - 3'd3;
    end
    if (fold >= 3'd3) begin
      fold = fold - 3'd3;
    end
    r3 = fold[1:0];
    if (r3[0] == b[0]) begin
      byte_mod6 = {1'b0, r3};
    end else begin
      byte_mod6 = {1'b0, r3} + 3'd3;
    end
  endfunction

endpackage

// ===== hdl/rsxbh_fold.sv =====
// one fold step of the rolling hash: restart handling, shift-add-xor and position update
`timescale 1ns / 1ps

module rsxbh_fold (
  input  rsxbh_pkg::hash_state_t        state_in,
  input  logic [rsxbh_pkg::HASH_W-1:0]  seed,
  input  logic [rsxbh_pkg::BYTE_W-1:0]  data_byte,
  input  logic                          first_byte,
  output rsxbh_pkg::hash_state_t        state_out
);

  logic [rsxbh_pkg::HASH_W-1:0]  h_start;
  logic [rsxbh_pkg::POS_W-1:0]   pos_start;
  logic [rsxbh_pkg::POS_W-1:0]   shamt1;
  logic [rsxbh_pkg::SHAMT_W-1:0] shamt2;
  logic [rsxbh_pkg::HASH_W-1:0]  b_ext;
  logic [rsxbh_pkg::HASH_W-1:0]  mix;
  logic [rsxbh_pkg::HASH_W-1:0]  t_val;

  // restart from the seed at position zero, otherwise carry on
  always_comb begin
    if (first_byte) begin
      h_start   = seed;
      pos_start = '0;
    end else begin
      h_start   = state_in.hash;
      pos_start = (state_in.pos > rsxbh_pkg::POS_LAST) ? '0 : state_in.pos;
    end
  end

  // t = h ^ ((b << (pos + 1)) + b)
  assign b_ext  = {{(rsxbh_pkg::HASH_W - rsxbh_pkg::BYTE_W){1'b0}}, data_byte};
  assign shamt1 = pos_start + 5'd1;
  assign mix    = (b_ext << shamt1) + b_ext;
  assign t_val  = h_start ^ mix;

  // h = (t << (b mod 6 + 2)) ^ t
  assign shamt2 = rsxbh_pkg::byte_mod6(data_byte) + rsxbh_pkg::SHAMT_BASE;

  always_comb begin
    state_out.hash = (t_val << shamt2) ^ t_val;
    state_out.pos  = (pos_start == rsxbh_pkg::POS_LAST) ? '0 : pos_start + 5'd1;
  end

endmodule

// ===== hdl/rolling_shift_xor_byte_hash_unit.sv =====
// top level: input register, fold step, hash state and result register
`timescale 1ns / 1ps

// Rolling shift-xor byte hash. Takes one byte per cycle while the result side does not
// stall and returns the running 32-bit hash after every byte, with final_res flagging
// the result of a byte marked last. A byte marked first restarts the hash from the seed
// register at position 0. The byte is captured in an input register, folded into the
// hash state by a single combinational step, and the new hash lands in the result
// register and the state register at the same edge, so a byte can be accepted every
// cycle while the result side does not stall. Stall on the result side propagates back
// to in_stall in the same cycle when the input register holds a byte. The seed is
// written through cfg_valid/cfg_seed (cfg_ready is always high) and takes effect at
// the next byte marked first; it resets to 0xCA074011, as does the running hash.

module rolling_shift_xor_byte_hash_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // input words
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rsxbh_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                          in_first_byte,
  input  logic                          in_last_byte,
  // result words
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rsxbh_pkg::HASH_W-1:0]  out_hash_value,
  output logic                          out_final_res,
  // seed register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rsxbh_pkg::HASH_W-1:0]  cfg_seed
);

  logic                          seed_we;
  logic [rsxbh_pkg::HASH_W-1:0]  seed_r;

  logic                          s1_valid_r;
  logic [rsxbh_pkg::BYTE_W-1:0]  s1_byte_r;
  logic                          s1_first_r;
  logic                          s1_last_r;

  rsxbh_pkg::hash_state_t        state_r;
  rsxbh_pkg::hash_state_t        state_nxt;

  logic                          out_valid_r;
  logic [rsxbh_pkg::HASH_W-1:0]  out_hash_r;
  logic                          out_final_r;

  logic                          advance;
  logic                          s1_move;
  logic                          in_take;

  // seed register, always ready
  assign cfg_ready = 1'b1;
  assign seed_we   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= rsxbh_pkg::SEED_RESET;
    end else if (seed_we) begin
      seed_r <= cfg_seed;
    end
  end

  // pipeline flow control
  assign advance  = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance || !s1_valid_r) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_data_byte;
      s1_first_r <= in_first_byte;
      s1_last_r  <= in_last_byte;
    end
  end

  // fold step
  rsxbh_fold u_fold (
    .state_in   (state_r),
    .seed       (seed_r),
    .data_byte  (s1_byte_r),
    .first_byte (s1_first_r),
    .state_out  (state_nxt)
  );

  // running hash and position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.hash <= rsxbh_pkg::SEED_RESET;
      state_r.pos  <= '0;
    end else if (s1_move) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_hash_r  <= state_nxt.hash;
      out_final_r <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;
  assign out_final_res  = out_final_r;

endmodule
